// ===== sv/lqss_pkg.sv =====
// Package with types and constants for the linear queue with sort and search.
`timescale 1ns / 1ps
package lqss_pkg;
   localparam int Depth = 128;
   localparam int DataWidth = 32;
   localparam int SlotWidth = $clog2(Depth);

   typedef enum logic [1:0] {
      CMD_ENQ = 2'd0, CMD_DEQ = 2'd1, CMD_SORT = 2'd2, CMD_SEARCH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic [6:0]         found_slot;
      logic               empty_now;
      logic               full_now;
   } rsp_type;
endpackage

// ===== sv/lqss_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lqss_ram #(
   parameter int Width = 32,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== sv/linear_queue_sort_search_top.sv =====
// Top level: command sequencer for the linear queue over one entry RAM.
//
//   channel | ports                 | direction | handshake
//   request | req_word, start, busy | in        | start && !busy
//   result  | rsp_word, rsp_strobe  | out       | one cycle strobe, no stall
//
// An enqueue goes from the accepting edge straight to the done state; a
// dequeue first passes through address, RAM read and capture. Search takes
// an address step and a compare step per entry examined. Sort is bubble
// sort with a read, read, compare sequence per pair and one more write step
// on a swap, n*(n-1)/2 compares for n entries. Reset is synchronous and
// clears the pointers; the RAM is not cleared. The result is shown for one
// cycle; busy stays high through that cycle, so the next word is taken in
// the cycle after the strobe.
`timescale 1ns / 1ps
module linear_queue_sort_search_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lqss_pkg::req_type req_word,
   output logic             busy,
   output logic             rsp_strobe,
   output lqss_pkg::rsp_type rsp_word
);
   localparam int SW = lqss_pkg::SlotWidth;
   localparam int DW = lqss_pkg::DataWidth;
   localparam logic [SW-1:0] LastSlot = SW'(lqss_pkg::Depth - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DEQ_RD, S_DEQ_WAIT, S_SRCH_RD, S_SRCH_CMP,
      S_SORT_RDA, S_SORT_RDB, S_SORT_CMP, S_SORT_WRB, S_DONE
   } state_type;

   state_type state_ff;
   logic [SW-1:0] head_ff, tail_ff, idx_ff, lim_ff;
   logic empty_ff;
   logic [DW-1:0] key_ff, a_ff;
   lqss_pkg::rsp_type rsp_ff;
   logic strobe_ff;

   logic ram_we;
   logic [SW-1:0] ram_addr;
   logic [DW-1:0] ram_wdata, ram_rdata;

   lqss_ram #(.Width(DW), .Depth(lqss_pkg::Depth)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   logic full_w;
   assign full_w = !empty_ff && (tail_ff == LastSlot);

   // RAM port control per state.
   always_comb begin
      ram_we = 1'b0;
      ram_addr = idx_ff;
      ram_wdata = a_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy && req_word.cmd == lqss_pkg::CMD_ENQ && !full_w) begin
               ram_we = 1'b1;
               ram_addr = empty_ff ? '0 : tail_ff + SW'(1);
               ram_wdata = DW'(req_word.operand_value);
            end
         end
         S_DEQ_RD: ram_addr = head_ff;
         S_SORT_RDB: ram_addr = idx_ff + SW'(1);
         S_SORT_CMP: begin
            // Swap: write the lower slot now, the upper slot next cycle.
            if ($signed(a_ff) > $signed(ram_rdata)) begin
               ram_we = 1'b1;
               ram_wdata = ram_rdata;
            end
         end
         S_SORT_WRB: begin
            ram_we = 1'b1;
            ram_addr = idx_ff + SW'(1);
            ram_wdata = a_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         empty_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start && !busy) begin
                  key_ff <= DW'(req_word.operand_value);
                  rsp_ff <= '0;
                  idx_ff <= head_ff;
                  lim_ff <= tail_ff;
                  unique case (req_word.cmd)
                     lqss_pkg::CMD_ENQ: begin
                        if (full_w) begin
                           rsp_ff.status <= lqss_pkg::ST_FULL;
                        end else if (empty_ff) begin
                           head_ff <= '0;
                           tail_ff <= '0;
                           empty_ff <= 1'b0;
                        end else begin
                           tail_ff <= tail_ff + SW'(1);
                        end
                        state_ff <= S_DONE;
                     end
                     lqss_pkg::CMD_DEQ: begin
                        if (empty_ff) begin
                           rsp_ff.status <= lqss_pkg::ST_EMPTY;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_DEQ_RD;
                        end
                     end
                     lqss_pkg::CMD_SORT: begin
                        state_ff <= (empty_ff || head_ff == tail_ff) ? S_DONE : S_SORT_RDA;
                     end
                     default: begin
                        if (empty_ff) begin
                           rsp_ff.status <= lqss_pkg::ST_NOT_FOUND;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_SRCH_RD;
                        end
                     end
                  endcase
               end
            end
            S_DEQ_RD: state_ff <= S_DEQ_WAIT;
            S_DEQ_WAIT: begin
               rsp_ff.removed_value <= 32'(ram_rdata);
               if (head_ff == tail_ff) begin
                  head_ff <= '0;
                  tail_ff <= '0;
                  empty_ff <= 1'b1;
               end else begin
                  head_ff <= head_ff + SW'(1);
               end
               state_ff <= S_DONE;
            end
            S_SRCH_RD: state_ff <= S_SRCH_CMP;
            S_SRCH_CMP: begin
               if (ram_rdata == key_ff) begin
                  rsp_ff.found_slot <= 7'(idx_ff);
                  state_ff <= S_DONE;
               end else if (idx_ff == tail_ff) begin
                  rsp_ff.status <= lqss_pkg::ST_NOT_FOUND;
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
                  state_ff <= S_SRCH_RD;
               end
            end
            S_SORT_RDA: state_ff <= S_SORT_RDB;
            S_SORT_RDB: begin
               a_ff <= ram_rdata;
               state_ff <= S_SORT_CMP;
            end
            S_SORT_CMP: begin
               if ($signed(a_ff) > $signed(ram_rdata)) begin
                  state_ff <= S_SORT_WRB;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
                  state_ff <= (idx_ff + SW'(1) == lim_ff) ? S_DONE : S_SORT_RDA;
                  if (idx_ff + SW'(1) == lim_ff) begin
                     // End of a pass: start the next, one slot shorter.
                     idx_ff <= head_ff;
                     lim_ff <= lim_ff - SW'(1);
                     state_ff <= (lim_ff - SW'(1) == head_ff) ? S_DONE : S_SORT_RDA;
                  end
               end
            end
            S_SORT_WRB: begin
               idx_ff <= idx_ff + SW'(1);
               state_ff <= S_SORT_RDA;
               if (idx_ff + SW'(1) == lim_ff) begin
                  idx_ff <= head_ff;
                  lim_ff <= lim_ff - SW'(1);
                  state_ff <= (lim_ff - SW'(1) == head_ff) ? S_DONE : S_SORT_RDA;
               end
            end
            S_DONE: begin
               strobe_ff <= 1'b1;
               rsp_ff.empty_now <= empty_ff;
               rsp_ff.full_now <= full_w;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The strobe cycle still counts as busy, so a new word is taken in the cycle after it.
   assign busy = (state_ff != S_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_word = rsp_ff;
endmodule

// ===== sv/lqss_checker.sv =====
// Port-level checker for the queue top level, with its bind statement.
`timescale 1ns / 1ps
module lqss_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input lqss_pkg::rsp_type rsp_word
);
   a_no_back_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held two cycles");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe while idle");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.empty_now && rsp_word.full_now))
      else $error("empty and full together");
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.status != lqss_pkg::ST_OK |-> rsp_word.removed_value == 0)
      else $error("removed value on failure");
endmodule

bind linear_queue_sort_search_top lqss_checker u_lqss_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
);
